@@ sv/sast_pkg.sv @@
// Shared constants and the beat record handed from cell to cell.
package sast_pkg;

  localparam int MAX_LEN      = 1024;
  localparam int ELEMENT_BITS = 16;
  localparam int TARGET_BITS  = 27;
  localparam int COUNT_BITS   = 20;

  localparam int TABLE_DEPTH = MAX_LEN + 1;
  localparam int PREFIX_BITS = $clog2(MAX_LEN) + ELEMENT_BITS;
  localparam int QUERY_BITS  = ((PREFIX_BITS > TARGET_BITS) ? PREFIX_BITS : TARGET_BITS) + 1;
  localparam int FREQ_BITS   = $clog2(TABLE_DEPTH + 1);
  localparam int SEEN_BITS   = $clog2(MAX_LEN + 1);

  // One element on its way down the chain of key/count cells.
  typedef struct packed {
    logic                   valid;  // stage holds a beat
    logic                   clear;  // beat starts a new array
    logic                   active; // element counted (not beyond MAX_LEN)
    logic [QUERY_BITS-1:0]  qkey;   // prefix - target, looked up
    logic [PREFIX_BITS-1:0] ikey;   // prefix, inserted or bumped
    logic                   done;   // insert already placed upstream
    logic [FREQ_BITS-1:0]   freq;   // frequency found for qkey
  } item_t;

endpackage

@@ sv/sast_cell.sv @@
// One table cell: holds a prefix key and its count, and a stage of the beat chain.
module sast_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             home,
  input  sast_pkg::item_t  up,
  output sast_pkg::item_t  down
);

  logic                             valid;
  logic [sast_pkg::PREFIX_BITS-1:0] key;
  logic [sast_pkg::FREQ_BITS-1:0]   freq;

  logic                             eff_valid;
  logic [sast_pkg::PREFIX_BITS-1:0] eff_key;
  logic [sast_pkg::FREQ_BITS-1:0]   eff_freq;
  logic [sast_pkg::QUERY_BITS-1:0]  key_ext;
  logic                             q_hit;
  logic                             claim;
  logic                             i_hit;
  logic                             valid_next;
  logic [sast_pkg::PREFIX_BITS-1:0] key_next;
  logic [sast_pkg::FREQ_BITS-1:0]   freq_next;
  sast_pkg::item_t                  down_next;

  always_comb begin
    // A clearing beat sees the cell as freshly reset.
    if (up.valid && up.clear) begin
      eff_valid = home;
      eff_key   = '0;
      eff_freq  = {{(sast_pkg::FREQ_BITS-1){1'b0}}, home};
    end else begin
      eff_valid = valid;
      eff_key   = key;
      eff_freq  = freq;
    end
    key_ext = {{(sast_pkg::QUERY_BITS-sast_pkg::PREFIX_BITS){eff_key[sast_pkg::PREFIX_BITS-1]}},
               eff_key};
    q_hit = up.valid && up.active && eff_valid && (key_ext == up.qkey);
    claim = up.valid && up.active && !up.done;
    i_hit = eff_valid && (eff_key == up.ikey);

    valid_next = eff_valid;
    key_next   = eff_key;
    freq_next  = eff_freq;
    down_next  = up;
    // Lookup uses the count before this beat's own bump.
    if (q_hit) begin
      down_next.freq = eff_freq;
    end
    if (claim && i_hit) begin
      freq_next      = eff_freq + 1'b1;
      down_next.done = 1'b1;
    end else if (claim && !eff_valid) begin
      valid_next     = 1'b1;
      key_next       = up.ikey;
      freq_next      = {{(sast_pkg::FREQ_BITS-1){1'b0}}, 1'b1};
      down_next.done = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= home;
      key        <= '0;
      freq       <= {{(sast_pkg::FREQ_BITS-1){1'b0}}, home};
      down.valid <= 1'b0;
    end else if (advance) begin
      if (up.valid) begin
        valid <= valid_next;
        key   <= key_next;
        freq  <= freq_next;
      end
      down <= down_next;
    end
  end

endmodule

@@ sv/subarray_sum_target_counter.sv @@
// Top level: prefix-sum subarray counter built on a chain of key/count cells.
//
// Counts the contiguous subarrays of a streamed signed array whose sum equals
// target_sum. Each accepted element beat forms its running prefix at the
// head, then walks a chain of MAX_LEN+1 cells, one cell per cycle while the output is not
// stalled; each cell holds one distinct prefix sum and its frequency. On the way the beat
// picks up the frequency of (prefix - target_sum) and bumps or places its own prefix in
// the first matching or free cell. A beat with start_of_array set clears each cell as it
// passes, so no clearing pass exists and beats behind it see the cleared table. Throughput
// is one element per cycle while the output is not stalled; a result passes the head
// stage, the cell chain and the output register. The whole chain holds when a result is
// stalled at the output. Elements beyond MAX_LEN in one array are not counted and return
// the current count with length_overflow set. target_sum is written through
// the cfg port (always ready) and is taken into each beat at the head.
module subarray_sum_target_counter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sast_pkg::TARGET_BITS-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sast_pkg::ELEMENT_BITS-1:0]   element,
  input  logic                                start_of_array,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sast_pkg::COUNT_BITS-1:0]     matching_count,
  output logic                                length_overflow
);

  localparam int DEPTH = sast_pkg::TABLE_DEPTH;
  localparam int QB    = sast_pkg::QUERY_BITS;
  localparam int PB    = sast_pkg::PREFIX_BITS;

  logic                            advance;
  logic [sast_pkg::TARGET_BITS-1:0] target_sum;
  logic [sast_pkg::SEEN_BITS-1:0]  seen;
  logic [PB-1:0]                   prefix;

  logic [sast_pkg::SEEN_BITS-1:0]  seen_base;
  logic [PB-1:0]                   prefix_base;
  logic [PB-1:0]                   prefix_next;
  logic                            over;
  logic                            accept;
  sast_pkg::item_t                 head_next;
  sast_pkg::item_t                 head;
  sast_pkg::item_t                 chain [DEPTH+1];

  logic [sast_pkg::COUNT_BITS-1:0] total;
  logic [sast_pkg::COUNT_BITS-1:0] total_base;
  logic [sast_pkg::COUNT_BITS:0]   total_sum;
  logic [sast_pkg::COUNT_BITS-1:0] total_next;

  // Hold the whole chain while a finished result waits at the output.
  assign advance   = !(out_valid && out_stall);
  assign in_stall  = !advance;
  assign accept    = in_valid && advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (cfg_valid) begin
      target_sum <= cfg_data;
    end
  end

  // Head: restart on start_of_array, mark elements beyond MAX_LEN as not counted, form keys.
  always_comb begin
    seen_base   = start_of_array ? '0 : seen;
    prefix_base = start_of_array ? '0 : prefix;
    over        = (seen_base >= sast_pkg::SEEN_BITS'(sast_pkg::MAX_LEN));
    prefix_next = prefix_base
                + {{(PB-sast_pkg::ELEMENT_BITS){element[sast_pkg::ELEMENT_BITS-1]}}, element};

    head_next.valid  = accept;
    head_next.clear  = start_of_array;
    head_next.active = !over;
    head_next.ikey   = prefix_next;
    head_next.qkey   = {{(QB-PB){prefix_next[PB-1]}}, prefix_next}
                     - {{(QB-sast_pkg::TARGET_BITS){target_sum[sast_pkg::TARGET_BITS-1]}},
                        target_sum};
    head_next.done   = 1'b0;
    head_next.freq   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen       <= '0;
      prefix     <= '0;
      head.valid <= 1'b0;
    end else if (advance) begin
      head <= head_next;
      if (accept) begin
        seen   <= over ? seen_base : seen_base + 1'b1;
        prefix <= over ? prefix_base : prefix_next;
      end
    end
  end

  assign chain[0] = head;

  // Row of key/count cells; cell zero is the one that holds sum zero after a clear.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sast_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .home    (i == 0),
      .up      (chain[i]),
      .down    (chain[i+1])
    );
  end

  // Tail: accumulate the found frequencies in order, saturate the total.
  always_comb begin
    total_base = chain[DEPTH].clear ? '0 : total;
    total_sum  = {1'b0, total_base}
               + {{(sast_pkg::COUNT_BITS+1-sast_pkg::FREQ_BITS){1'b0}}, chain[DEPTH].freq};
    if (!chain[DEPTH].active) begin
      total_next = total_base;
    end else if (total_sum[sast_pkg::COUNT_BITS]) begin
      total_next = '1;
    end else begin
      total_next = total_sum[sast_pkg::COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= chain[DEPTH].valid;
      if (chain[DEPTH].valid) begin
        total           <= total_next;
        matching_count  <= total_next;
        length_overflow <= !chain[DEPTH].active;
      end
    end
  end

endmodule
